>>> rtl/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg: shared definitions of the IMU fall detector
// Widths, phase and event codes, register indexes, reset values and the
// configuration bundle that the register file hands to the phase machine.
// ----------------------------------------------------------------------------
package ifd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SQUARE_W  = 31;  // (2^15)^2 = 2^30 needs 31 bits
	localparam int ENERGY_W  = 32;  // sum of three squares, at most 3*2^30
	localparam int TICK_W    = 32;
	localparam int LEVEL_W   = 32;
	localparam int SPAN_W    = 16;
	localparam int LANES     = 6;
	localparam int AXES      = 3;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 72;
	localparam int ADDR_W     = 5;
	localparam int PDATA_W    = 32;

	// Time the alarm is held in the motionless phase, in milliseconds.
	localparam logic [TICK_W-1:0] MOTIONLESS_HOLD_MS = 32'd3000;

	typedef enum logic [1:0] {
		PH_NORMAL     = 2'd0,
		PH_FREEFALL   = 2'd1,
		PH_IMPACT     = 2'd2,
		PH_MOTIONLESS = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_FREEFALL  = 3'd1,
		EV_IMPACT    = 3'd2,
		EV_TIMEOUT   = 3'd3,
		EV_CONFIRMED = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		REG_FREEFALL_LEVEL = 3'd0,
		REG_IMPACT_LEVEL   = 3'd1,
		REG_ROTATION_LEVEL = 3'd2,
		REG_STILL_LOWER    = 3'd3,
		REG_STILL_UPPER    = 3'd4,
		REG_IMPACT_WINDOW  = 3'd5,
		REG_IMPACT_LIMIT   = 3'd6,
		REG_STILL_DURATION = 3'd7
	} reg_idx_t;

	localparam logic [LEVEL_W-1:0] RST_FREEFALL_LEVEL = 32'd67108864;
	localparam logic [LEVEL_W-1:0] RST_IMPACT_LEVEL   = 32'd1073741824;
	localparam logic [LEVEL_W-1:0] RST_ROTATION_LEVEL = 32'd100000000;
	localparam logic [LEVEL_W-1:0] RST_STILL_LOWER    = 32'd201326592;
	localparam logic [LEVEL_W-1:0] RST_STILL_UPPER    = 32'd339738624;
	localparam logic [SPAN_W-1:0]  RST_IMPACT_WINDOW  = 16'd500;
	localparam logic [SPAN_W-1:0]  RST_IMPACT_LIMIT   = 16'd5000;
	localparam logic [SPAN_W-1:0]  RST_STILL_DURATION = 16'd2000;

	typedef struct packed {
		logic [LEVEL_W-1:0] freefall_level;
		logic [LEVEL_W-1:0] impact_level;
		logic [LEVEL_W-1:0] rotation_level;
		logic [LEVEL_W-1:0] still_lower;
		logic [LEVEL_W-1:0] still_upper;
		logic [SPAN_W-1:0]  impact_window;
		logic [SPAN_W-1:0]  impact_limit;
		logic [SPAN_W-1:0]  still_duration;
	} cfg_t;

endpackage

>>> rtl/imu_fall_detector.sv
// ----------------------------------------------------------------------------
// imu_fall_detector: threshold fall detector for IMU sample streams
// Six squaring lanes, a merge stage and a four-phase fall machine behind a
// stream interface, with an APB-style register file for the thresholds.
// ----------------------------------------------------------------------------
// Each sample transfer on the slave stream carries three signed accelerometer
// axes, three signed gyro axes and a 32-bit millisecond timestamp, and yields
// exactly one result transfer on the master stream: the event code, the phase
// after the sample and the two squared magnitudes. The datapath is a
// three-stage pipeline: six parallel lanes square one axis each, the merge
// stage adds them into the acceleration and rotation energies, and the phase
// machine updates its state and registers the result. One sample is taken
// every cycle as long as the master side keeps up; each stage carries its
// own valid bit, so a stalled result only holds back the stages behind it
// once they are full. The user is to write the thresholds and time spans
// through the register port only while no sample is in flight; the block
// does not enforce this. Time differences are taken modulo 2^32, so a
// wrapping timestamp needs no special handling.
// ----------------------------------------------------------------------------
module imu_fall_detector
	import ifd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Sample stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// From bit 0: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits
	// each, signed), timestamp (32 bits).
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// From bit 0: event_code (3), phase (2), accel_energy (32),
	// rotation_energy (32), zero fill (3).
	output logic [OUT_DATA_W-1:0] m_tdata,
	// Register port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	cfg_t                 cfg;
	logic                 valid_s1;
	logic                 s_load;
	logic [TICK_W-1:0]    tick_s1;
	logic [SQUARE_W-1:0]  squares_s1 [LANES];
	logic                 merge_ready;
	logic                 merge_valid;
	logic [ENERGY_W-1:0]  accel_s2;
	logic [ENERGY_W-1:0]  rotation_s2;
	logic [TICK_W-1:0]    tick_s2;
	logic                 fsm_ready;
	event_t               res_event;
	phase_t               res_phase;
	logic [ENERGY_W-1:0]  res_accel;
	logic [ENERGY_W-1:0]  res_rotation;

	ifd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The first stage is free when it is empty or when the merge stage takes
	// its content in the same cycle.
	assign s_tready = !valid_s1 || merge_ready;
	assign s_load   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_load) begin
			tick_s1 <= s_tdata[LANES*SAMPLE_W +: TICK_W];
		end
	end

	// One squaring lane per axis; lanes 0 to 2 are the accelerometer, lanes 3
	// to 5 the gyro, in the order the axes are packed in the sample.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ifd_square_lane u_lane (
			.clk       (clk),
			.load      (s_load),
			.sample    (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
			.square_s1 (squares_s1[g])
		);
	end

	ifd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.in_ready    (merge_ready),
		.squares     (squares_s1),
		.tick_in     (tick_s1),
		.out_valid   (merge_valid),
		.out_ready   (fsm_ready),
		.accel_s2    (accel_s2),
		.rotation_s2 (rotation_s2),
		.tick_s2     (tick_s2)
	);

	ifd_phase_fsm u_phase_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (merge_valid),
		.in_ready     (fsm_ready),
		.accel        (accel_s2),
		.rotation     (rotation_s2),
		.tick         (tick_s2),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_event    (res_event),
		.out_phase    (res_phase),
		.out_accel    (res_accel),
		.out_rotation (res_rotation)
	);

	assign m_tdata = {3'b000, res_rotation, res_accel, res_phase, res_event};

endmodule

>>> rtl/ifd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ifd_cfg_regs: configuration register file
// APB-style write and read of the eight detector thresholds and time spans.
// ----------------------------------------------------------------------------
module ifd_cfg_regs
	import ifd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freefall_level <= RST_FREEFALL_LEVEL;
			cfg_q.impact_level   <= RST_IMPACT_LEVEL;
			cfg_q.rotation_level <= RST_ROTATION_LEVEL;
			cfg_q.still_lower    <= RST_STILL_LOWER;
			cfg_q.still_upper    <= RST_STILL_UPPER;
			cfg_q.impact_window  <= RST_IMPACT_WINDOW;
			cfg_q.impact_limit   <= RST_IMPACT_LIMIT;
			cfg_q.still_duration <= RST_STILL_DURATION;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FREEFALL_LEVEL: cfg_q.freefall_level <= pwdata;
				REG_IMPACT_LEVEL:   cfg_q.impact_level   <= pwdata;
				REG_ROTATION_LEVEL: cfg_q.rotation_level <= pwdata;
				REG_STILL_LOWER:    cfg_q.still_lower    <= pwdata;
				REG_STILL_UPPER:    cfg_q.still_upper    <= pwdata;
				REG_IMPACT_WINDOW:  cfg_q.impact_window  <= pwdata[SPAN_W-1:0];
				REG_IMPACT_LIMIT:   cfg_q.impact_limit   <= pwdata[SPAN_W-1:0];
				REG_STILL_DURATION: cfg_q.still_duration <= pwdata[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FREEFALL_LEVEL: prdata = cfg_q.freefall_level;
			REG_IMPACT_LEVEL:   prdata = cfg_q.impact_level;
			REG_ROTATION_LEVEL: prdata = cfg_q.rotation_level;
			REG_STILL_LOWER:    prdata = cfg_q.still_lower;
			REG_STILL_UPPER:    prdata = cfg_q.still_upper;
			REG_IMPACT_WINDOW:  prdata = {16'd0, cfg_q.impact_window};
			REG_IMPACT_LIMIT:   prdata = {16'd0, cfg_q.impact_limit};
			REG_STILL_DURATION: prdata = {16'd0, cfg_q.still_duration};
			default:            prdata = '0;
		endcase
	end

endmodule

>>> rtl/ifd_square_lane.sv
// ----------------------------------------------------------------------------
// ifd_square_lane: one axis lane
// Takes the magnitude of a signed 16-bit sample and registers its square.
// ----------------------------------------------------------------------------
module ifd_square_lane
	import ifd_pkg::*;
(
	input  logic                       clk,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic [SQUARE_W-1:0]        square_s1
);

	logic [SAMPLE_W-1:0]   mag;
	logic [2*SAMPLE_W-1:0] product;

	// The most negative code maps to 0x8000, which is its true magnitude.
	assign mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
	assign product = {{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag};

	always_ff @(posedge clk) begin
		if (load) begin
			square_s1 <= product[SQUARE_W-1:0];
		end
	end

endmodule

>>> rtl/ifd_merge.sv
// ----------------------------------------------------------------------------
// ifd_merge: lane merge stage
// Adds the three accelerometer squares and the three gyro squares into the
// two energies and registers them together with the sample's timestamp.
// ----------------------------------------------------------------------------
module ifd_merge
	import ifd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SQUARE_W-1:0] squares [LANES],
	input  logic [TICK_W-1:0]   tick_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ENERGY_W-1:0] accel_s2,
	output logic [ENERGY_W-1:0] rotation_s2,
	output logic [TICK_W-1:0]   tick_s2
);

	logic                valid_s2;
	logic                load;
	logic [ENERGY_W-1:0] accel_sum;
	logic [ENERGY_W-1:0] rotation_sum;

	assign in_ready  = !valid_s2 || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = valid_s2;

	assign accel_sum = ENERGY_W'(squares[0]) + ENERGY_W'(squares[1])
		+ ENERGY_W'(squares[2]);
	assign rotation_sum = ENERGY_W'(squares[AXES]) + ENERGY_W'(squares[AXES+1])
		+ ENERGY_W'(squares[AXES+2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			accel_s2    <= accel_sum;
			rotation_s2 <= rotation_sum;
			tick_s2     <= tick_in;
		end
	end

endmodule

>>> rtl/ifd_phase_fsm.sv
// ----------------------------------------------------------------------------
// ifd_phase_fsm: fall phase machine and result register
// Advances normal, free fall, impact and motionless on the two energies and
// the millisecond tick, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ifd_phase_fsm
	import ifd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ENERGY_W-1:0] accel,
	input  logic [ENERGY_W-1:0] rotation,
	input  logic [TICK_W-1:0]   tick,
	output logic                out_valid,
	input  logic                out_ready,
	output event_t              out_event,
	output phase_t              out_phase,
	output logic [ENERGY_W-1:0] out_accel,
	output logic [ENERGY_W-1:0] out_rotation
);

	phase_t              phase_q;
	phase_t              phase_n;
	logic [TICK_W-1:0]   start_q;
	logic [TICK_W-1:0]   start_n;
	logic [TICK_W-1:0]   impact_q;
	logic [TICK_W-1:0]   impact_n;
	event_t              event_n;
	logic [TICK_W-1:0]   since_start;
	logic [TICK_W-1:0]   since_impact;
	logic                is_still;
	logic                load;

	logic                valid_q;
	event_t              event_q;
	phase_t              res_phase_q;
	logic [ENERGY_W-1:0] accel_q;
	logic [ENERGY_W-1:0] rotation_q;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	assign since_start  = tick - start_q;
	assign since_impact = tick - impact_q;
	assign is_still     = (accel > cfg.still_lower) && (accel < cfg.still_upper);

	always_comb begin
		phase_n  = phase_q;
		start_n  = start_q;
		impact_n = impact_q;
		event_n  = EV_NONE;
		case (phase_q)
			PH_NORMAL: begin
				if (accel < cfg.freefall_level) begin
					phase_n = PH_FREEFALL;
					start_n = tick;
					event_n = EV_FREEFALL;
				end
			end
			PH_FREEFALL: begin
				if (accel > cfg.impact_level && rotation > cfg.rotation_level
						&& since_start <= {16'd0, cfg.impact_window}) begin
					phase_n  = PH_IMPACT;
					start_n  = tick;
					impact_n = tick;
					event_n  = EV_IMPACT;
				end else if (since_start > {16'd0, cfg.impact_window}) begin
					phase_n = PH_NORMAL;
					event_n = EV_TIMEOUT;
				end
			end
			PH_IMPACT: begin
				// Any sample outside the still band restarts the stillness run.
				if (is_still) begin
					if (since_start >= {16'd0, cfg.still_duration}) begin
						phase_n = PH_MOTIONLESS;
						start_n = tick;
						event_n = EV_CONFIRMED;
					end
				end else begin
					start_n = tick;
				end
				if (event_n == EV_NONE && since_impact > {16'd0, cfg.impact_limit}) begin
					phase_n = PH_NORMAL;
					event_n = EV_TIMEOUT;
				end
			end
			PH_MOTIONLESS: begin
				if (since_start >= MOTIONLESS_HOLD_MS) begin
					phase_n = PH_NORMAL;
				end
			end
			default: begin
				phase_n = PH_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NORMAL;
			start_q  <= '0;
			impact_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				phase_q  <= phase_n;
				start_q  <= start_n;
				impact_q <= impact_n;
			end
			if (in_ready) begin
				valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_q     <= event_n;
			res_phase_q <= phase_n;
			accel_q     <= accel;
			rotation_q  <= rotation;
		end
	end

	assign out_valid    = valid_q;
	assign out_event    = event_q;
	assign out_phase    = res_phase_q;
	assign out_accel    = accel_q;
	assign out_rotation = rotation_q;

`ifndef SYNTHESIS
	a_freefall_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && event_q == EV_FREEFALL |-> res_phase_q == PH_FREEFALL)
		else $error("free fall event without free fall phase");

	a_impact_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && event_q == EV_IMPACT |-> res_phase_q == PH_IMPACT)
		else $error("impact event without impact phase");

	a_timeout_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (event_q == EV_TIMEOUT) |-> res_phase_q == PH_NORMAL)
		else $error("timeout event did not return to normal");

	a_confirm_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && event_q == EV_CONFIRMED |-> res_phase_q == PH_MOTIONLESS)
		else $error("confirmed fall without motionless phase");

	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(phase_q) && $stable(start_q) && $stable(impact_q))
		else $error("phase state changed without an accepted sample");
`endif

endmodule
